// File: rtl/rse_pkg.sv
// shared types, codes and default sizes for the rpn stack evaluator
// no dependencies; all sv files but rse_fifo refer to it by scoped names
package rse_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int LIT_WIDTH   = 32;
   localparam int DEPTH_WIDTH = 7;

   // command codes on the request beat
   localparam logic [2:0] CMD_PUSH = 3'd0;
   localparam logic [2:0] CMD_ADD  = 3'd1;
   localparam logic [2:0] CMD_SUB  = 3'd2;
   localparam logic [2:0] CMD_MUL  = 3'd3;
   localparam logic [2:0] CMD_DIV  = 3'd4;

   // status codes on the response beat
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [1:0] ST_DIV_ZERO  = 2'd3;

   typedef enum logic [2:0] {
      OP_PUSH,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_NOP
   } rse_op_type;

   typedef struct packed {
      logic [2:0]                  command;
      logic signed [LIT_WIDTH-1:0] literal;
      logic                        last;
   } rse_req_type;

   typedef struct packed {
      logic signed [LIT_WIDTH-1:0] top_value;
      logic [DEPTH_WIDTH-1:0]      depth;
      logic [1:0]                  status;
      logic                        expression_done;
   } rse_rsp_type;

   // classified token handed from front to back
   typedef struct packed {
      rse_op_type                  op;
      logic signed [LIT_WIDTH-1:0] literal;
      logic                        last;
   } rse_work_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } rse_iter_ctl_type;

endpackage

// File: rtl/rse_fifo.sv
// small register queue with full and empty flags
// depends on nothing; used for the token queue and the response queue
module rse_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/rse_front.sv
// front end: takes request beats, decodes the command and queues the token
// depends on rse_pkg and rse_fifo
module rse_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  rse_pkg::rse_req_type req_data,
   input  logic                 work_pop,
   output logic                 work_empty,
   output rse_pkg::rse_work_type work_data
);

   rse_pkg::rse_work_type work_in;
   rse_pkg::rse_op_type   op_in;

   always_comb begin
      unique case (req_data.command)
         rse_pkg::CMD_PUSH: op_in = rse_pkg::OP_PUSH;
         rse_pkg::CMD_ADD:  op_in = rse_pkg::OP_ADD;
         rse_pkg::CMD_SUB:  op_in = rse_pkg::OP_SUB;
         rse_pkg::CMD_MUL:  op_in = rse_pkg::OP_MUL;
         rse_pkg::CMD_DIV:  op_in = rse_pkg::OP_DIV;
         default:           op_in = rse_pkg::OP_NOP;
      endcase
      work_in.op      = op_in;
      work_in.literal = req_data.literal;
      work_in.last    = req_data.last;
   end

   rse_fifo #(
      .WIDTH ($bits(rse_pkg::rse_work_type)),
      .DEPTH (rse_pkg::QUEUE_DEPTH)
   ) u_token_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .wr_data (work_in),
      .pop     (work_pop),
      .empty   (work_empty),
      .rd_data (work_data)
   );

endmodule

// File: rtl/rse_iter.sv
// shared iterative unit: shift-add multiply and signed restoring divide,
// one bit per cycle; depends on rse_pkg
module rse_iter #(
   parameter int DATA_WIDTH = rse_pkg::DATA_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rse_pkg::rse_iter_ctl_type ctl,
   input  logic [DATA_WIDTH-1:0]     a,
   input  logic [DATA_WIDTH-1:0]     b,
   output logic                      done,
   output logic [DATA_WIDTH-1:0]     result
);

   localparam int CW = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic                  is_div_ff;
   logic                  neg_ff;
   logic [CW-1:0]         cnt_ff;
   logic [DATA_WIDTH-1:0] acc_ff;
   logic [DATA_WIDTH-1:0] x_ff;
   logic [DATA_WIDTH-1:0] y_ff;

   logic [DATA_WIDTH-1:0] a_mag;
   logic [DATA_WIDTH-1:0] b_mag;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   diff;
   logic                  q_bit;

   assign a_mag = a[DATA_WIDTH-1] ? (~a + DATA_WIDTH'(1)) : a;
   assign b_mag = b[DATA_WIDTH-1] ? (~b + DATA_WIDTH'(1)) : b;

   // restoring step: bring in the next dividend bit, subtract if it fits
   assign trial = {acc_ff, x_ff[DATA_WIDTH-1]};
   assign diff  = trial - {1'b0, y_ff};
   assign q_bit = (trial >= {1'b0, y_ff});

   assign done   = done_ff;
   assign result = is_div_ff ? (neg_ff ? (~x_ff + DATA_WIDTH'(1)) : x_ff) : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff   <= 1'b1;
            cnt_ff    <= CW'(DATA_WIDTH);
            is_div_ff <= ctl.is_div;
            acc_ff    <= '0;
            if (ctl.is_div) begin
               x_ff   <= a_mag;
               y_ff   <= b_mag;
               neg_ff <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
            end else begin
               x_ff   <= a;
               y_ff   <= b;
               neg_ff <= 1'b0;
            end
         end else if (busy_ff) begin
            if (is_div_ff) begin
               acc_ff <= q_bit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
               x_ff   <= {x_ff[DATA_WIDTH-2:0], q_bit};
            end else begin
               if (y_ff[0]) begin
                  acc_ff <= acc_ff + x_ff;
               end
               x_ff <= {x_ff[DATA_WIDTH-2:0], 1'b0};
               y_ff <= {1'b0, y_ff[DATA_WIDTH-1:1]};
            end
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// File: rtl/rse_exec.sv
// back end: operand stack memory, top-of-stack register and sequencer
// depends on rse_pkg and rse_iter
module rse_exec #(
   parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH,
   parameter int DATA_WIDTH  = rse_pkg::DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   output logic                  work_pop,
   input  logic                  work_empty,
   input  rse_pkg::rse_work_type work_data,
   output logic                  rsp_push,
   input  logic                  rsp_full,
   output rse_pkg::rse_rsp_type  rsp_data
);

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
   localparam logic [SPW-1:0] SP_TWO  = SPW'(2);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_WAIT,
      S_RESP
   } state_type;

   state_type             state_ff;
   logic [SPW-1:0]        sp_ff;
   logic [DATA_WIDTH-1:0] top_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   rse_pkg::rse_op_type   op_ff;
   logic                  last_ff;
   logic [1:0]            status_ff;

   // entries below the top one; the top lives in top_ff
   logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];

   logic [SPW-1:0]        sp_dec;
   logic [SPW-1:0]        sp_dec2;
   logic                  mem_we;
   logic                  mem_re;
   logic                  is_arith;
   logic [DATA_WIDTH-1:0] lit_ext;
   logic [DATA_WIDTH-1:0] top_out;
   logic                  take;

   rse_pkg::rse_iter_ctl_type iter_ctl;
   logic                      iter_done;
   logic [DATA_WIDTH-1:0]     iter_result;

   assign sp_dec  = sp_ff - SPW'(1);
   assign sp_dec2 = sp_ff - SPW'(2);
   assign take    = (state_ff == S_IDLE) && !work_empty;
   assign work_pop = take;
   assign is_arith = (work_data.op == rse_pkg::OP_ADD) || (work_data.op == rse_pkg::OP_SUB) ||
                     (work_data.op == rse_pkg::OP_MUL) || (work_data.op == rse_pkg::OP_DIV);
   assign mem_we = take && (work_data.op == rse_pkg::OP_PUSH) &&
                   (sp_ff != '0) && (sp_ff != SP_FULL);
   assign mem_re = take && is_arith && (sp_ff >= SP_TWO);

   // literal resized to the stack width, sign-extended when wider
   always_comb begin
      for (int i = 0; i < DATA_WIDTH; i++) begin
         lit_ext[i] = work_data.literal[(i < rse_pkg::LIT_WIDTH) ? i : rse_pkg::LIT_WIDTH - 1];
      end
   end

   assign top_out = (sp_ff != '0) ? top_ff : '0;

   always_comb begin
      for (int i = 0; i < rse_pkg::LIT_WIDTH; i++) begin
         rsp_data.top_value[i] = (i < DATA_WIDTH) ?
                                 top_out[(i < DATA_WIDTH) ? i : DATA_WIDTH - 1] : 1'b0;
      end
      for (int i = 0; i < rse_pkg::DEPTH_WIDTH; i++) begin
         rsp_data.depth[i] = (i < SPW) ? sp_ff[(i < SPW) ? i : SPW - 1] : 1'b0;
      end
      rsp_data.status          = status_ff;
      rsp_data.expression_done = last_ff;
   end

   assign rsp_push = (state_ff == S_RESP);

   assign iter_ctl.start  = (state_ff == S_CALC) &&
                            ((op_ff == rse_pkg::OP_MUL) ||
                             ((op_ff == rse_pkg::OP_DIV) && (top_ff != '0)));
   assign iter_ctl.is_div = (op_ff == rse_pkg::OP_DIV);

   rse_iter #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_iter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (iter_ctl),
      .a      (rd_data_ff),
      .b      (top_ff),
      .done   (iter_done),
      .result (iter_result)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[sp_dec[AW-1:0]] <= top_ff;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[sp_dec2[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (take) begin
                  op_ff     <= work_data.op;
                  last_ff   <= work_data.last;
                  status_ff <= rse_pkg::ST_OK;
                  unique case (work_data.op) inside
                     rse_pkg::OP_PUSH: begin
                        if (sp_ff == SP_FULL) begin
                           status_ff <= rse_pkg::ST_OVERFLOW;
                        end else begin
                           top_ff <= lit_ext;
                           sp_ff  <= sp_ff + SPW'(1);
                        end
                        state_ff <= S_RESP;
                     end
                     rse_pkg::OP_ADD, rse_pkg::OP_SUB, rse_pkg::OP_MUL, rse_pkg::OP_DIV: begin
                        if (sp_ff < SP_TWO) begin
                           status_ff <= rse_pkg::ST_UNDERFLOW;
                           state_ff  <= S_RESP;
                        end else begin
                           state_ff <= S_CALC;
                        end
                     end
                     default: begin
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end
            S_CALC: begin
               // left operand in rd_data_ff, right operand in top_ff
               unique case (op_ff) inside
                  rse_pkg::OP_ADD: begin
                     top_ff   <= rd_data_ff + top_ff;
                     sp_ff    <= sp_dec;
                     state_ff <= S_RESP;
                  end
                  rse_pkg::OP_SUB: begin
                     top_ff   <= rd_data_ff - top_ff;
                     sp_ff    <= sp_dec;
                     state_ff <= S_RESP;
                  end
                  rse_pkg::OP_DIV: begin
                     if (top_ff == '0) begin
                        status_ff <= rse_pkg::ST_DIV_ZERO;
                        state_ff  <= S_RESP;
                     end else begin
                        state_ff <= S_WAIT;
                     end
                  end
                  rse_pkg::OP_MUL: begin
                     state_ff <= S_WAIT;
                  end
                  default: begin
                     state_ff <= S_RESP;
                  end
               endcase
            end
            S_WAIT: begin
               if (iter_done) begin
                  top_ff   <= iter_result;
                  sp_ff    <= sp_dec;
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (!rsp_full) begin
                  if (last_ff) begin
                     sp_ff <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: rtl/rpn_stack_evaluator.sv
// rpn stack evaluator top: token queue, stack sequencer, response queue.
// push, no-op and underflow go from idle to the response state; add, subtract
// and divide by zero pass the calc state; multiply and divide also wait on
// the one-bit-per-cycle multiply/divide unit. a token is taken only after
// the prior response beat enters the response queue; synchronous reset
// empties both queues and the stack, the stack memory contents are not swept
module rpn_stack_evaluator #(
   parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH,
   parameter int DATA_WIDTH  = rse_pkg::DATA_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  rse_pkg::rse_req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rse_pkg::rse_rsp_type rsp_data
);

   logic                  work_pop;
   logic                  work_empty;
   rse_pkg::rse_work_type work_data;
   logic                  rsp_push;
   logic                  rsp_q_full;
   rse_pkg::rse_rsp_type  rsp_beat;

   rse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .work_pop   (work_pop),
      .work_empty (work_empty),
      .work_data  (work_data)
   );

   rse_exec #(
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_exec (
      .clock      (clock),
      .reset      (reset),
      .work_pop   (work_pop),
      .work_empty (work_empty),
      .work_data  (work_data),
      .rsp_push   (rsp_push),
      .rsp_full   (rsp_q_full),
      .rsp_data   (rsp_beat)
   );

   rse_fifo #(
      .WIDTH ($bits(rse_pkg::rse_rsp_type)),
      .DEPTH (rse_pkg::QUEUE_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .full    (rsp_q_full),
      .wr_data (rsp_beat),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_data)
   );

   // the sequencer takes a token only from a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      work_pop |-> !work_empty)
      else $error("token taken from empty queue");

   // a response held back by a full queue stays until it goes in
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_q_full) |=> (rsp_push && $stable(rsp_beat)))
      else $error("response dropped or changed while stalled");

   // underflow is reported only with fewer than two entries
   a_underflow_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && (rsp_beat.status == rse_pkg::ST_UNDERFLOW)) |-> (rsp_beat.depth < 2))
      else $error("underflow with enough operands");

endmodule

// File: tb/rse_checker.sv
// response checker for the rpn stack evaluator: tracks the operand stack beside the block,
// predicts every response beat and compares it with what comes out of the block
// depends on rse_pkg for beat types, command codes and status codes
module rse_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_full,
   input  rse_pkg::rse_req_type req_data,
   input  logic                 rsp_empty,
   input  logic                 rsp_pop,
   input  rse_pkg::rse_rsp_type rsp_data,
   output int                   fail_count,
   output int                   outstanding
);

   logic [rse_pkg::DATA_WIDTH-1:0] operands [rse_pkg::STACK_DEPTH];
   int                             level = 0;
   int                             errors = 0;
   rse_pkg::rse_rsp_type           expected_rsp_q [$];

   function automatic logic [rse_pkg::DATA_WIDTH-1:0] div_toward_zero(
      input logic [rse_pkg::DATA_WIDTH-1:0] lhs,
      input logic [rse_pkg::DATA_WIDTH-1:0] rhs
   );
      logic [rse_pkg::DATA_WIDTH-1:0] lhs_mag;
      logic [rse_pkg::DATA_WIDTH-1:0] rhs_mag;
      logic [rse_pkg::DATA_WIDTH-1:0] quo;
      lhs_mag = lhs[rse_pkg::DATA_WIDTH-1] ? -lhs : lhs;
      rhs_mag = rhs[rse_pkg::DATA_WIDTH-1] ? -rhs : rhs;
      quo = lhs_mag / rhs_mag;
      if (lhs[rse_pkg::DATA_WIDTH-1] ^ rhs[rse_pkg::DATA_WIDTH-1]) begin
         quo = -quo;
      end
      return quo;
   endfunction

   // applies one token to the shadow stack and returns the response it should produce
   function automatic rse_pkg::rse_rsp_type apply_token(input rse_pkg::rse_req_type tok);
      rse_pkg::rse_rsp_type           res;
      logic [rse_pkg::DATA_WIDTH-1:0] lhs;
      logic [rse_pkg::DATA_WIDTH-1:0] rhs;
      logic [rse_pkg::DATA_WIDTH-1:0] val;
      logic                           ok;
      res = '0;
      res.status = rse_pkg::ST_OK;
      res.expression_done = tok.last;
      if (tok.command == rse_pkg::CMD_PUSH) begin
         if (level >= rse_pkg::STACK_DEPTH) begin
            res.status = rse_pkg::ST_OVERFLOW;
         end else begin
            operands[level] = tok.literal;
            level++;
         end
      end else if (tok.command <= rse_pkg::CMD_DIV) begin
         if (level < 2) begin
            res.status = rse_pkg::ST_UNDERFLOW;
         end else begin
            rhs = operands[level-1];
            lhs = operands[level-2];
            val = '0;
            ok  = 1'b1;
            case (tok.command)
               rse_pkg::CMD_ADD: val = lhs + rhs;
               rse_pkg::CMD_SUB: val = lhs - rhs;
               rse_pkg::CMD_MUL: val = lhs * rhs;
               default: begin
                  if (rhs == '0) begin
                     ok = 1'b0;
                     res.status = rse_pkg::ST_DIV_ZERO;
                  end else begin
                     val = div_toward_zero(lhs, rhs);
                  end
               end
            endcase
            if (ok) begin
               operands[level-2] = val;
               level--;
            end
         end
      end
      // spare command codes fall through and leave the stack alone
      res.top_value = (level > 0) ? operands[level-1] : '0;
      res.depth = level[rse_pkg::DEPTH_WIDTH-1:0];
      if (tok.last) begin
         level = 0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rse_pkg::rse_rsp_type want;
      if (reset) begin
         level = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response beat with no expected result");
               errors++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.top_value !== want.top_value) begin
                  $error("top_value expected %0d got %0d", want.top_value, rsp_data.top_value);
                  errors++;
               end
               if (rsp_data.depth !== want.depth) begin
                  $error("depth expected %0d got %0d", want.depth, rsp_data.depth);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.expression_done !== want.expression_done) begin
                  $error("expression_done expected %0d got %0d",
                         want.expression_done, rsp_data.expression_done);
                  errors++;
               end
            end
         end
         if (req_push && !req_full) begin
            expected_rsp_q.push_back(apply_token(req_data));
         end
      end
      fail_count  <= errors;
      outstanding <= expected_rsp_q.size();
   end

endmodule

// File: tb/tb_rpn_stack_evaluator.sv
// top of the rpn stack evaluator testbench: clock, reset, token stimulus and verdict
// depends on rse_pkg, the rpn_stack_evaluator block and the rse_checker module
module tb_rpn_stack_evaluator;

   // command codes with no operation behind them
   localparam logic [2:0] CMD_RSVD5 = 3'd5;
   localparam logic [2:0] CMD_RSVD6 = 3'd6;
   localparam logic [2:0] CMD_RSVD7 = 3'd7;

   localparam int ITEMS_PER_PHASE = 115;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = rse_pkg::DATA_WIDTH + 8;

   logic                 clock;
   logic                 reset    = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   rse_pkg::rse_req_type req_data = '0;
   logic                 rsp_empty;
   logic                 rsp_pop  = 1'b0;
   rse_pkg::rse_rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int push_idle_pct = 0;
   int pop_stall_pct = 0;
   int tokens_sent   = 0;
   int idle_cycles   = 0;

   rpn_stack_evaluator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   rse_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= pop_stall_pct);
   end

   // ends the run when no beat moves on either side for too long
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("FAIL rpn_stack_evaluator");
      $finish;
   end

   function automatic rse_pkg::rse_req_type make_token(
      input logic [2:0]  cmd,
      input logic [31:0] lit,
      input logic        fin
   );
      rse_pkg::rse_req_type tok;
      tok.command = cmd;
      tok.literal = lit;
      tok.last    = fin;
      return tok;
   endfunction

   function automatic logic [31:0] rand_literal();
      case ($urandom_range(5))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return $urandom_range(20) - 10;
         3:       return $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   // push stays high when the next call follows in the same step
   task automatic send_token(input rse_pkg::rse_req_type tok);
      while ($urandom_range(99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= tok;
      do @(posedge clock); while (req_full);
      tokens_sent++;
   endtask

   task automatic hold_sender();
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // pushes a run of literals and closes it with an add marked last
   task automatic send_fill(input int count);
      for (int i = 0; i < count; i++) begin
         send_token(make_token(rse_pkg::CMD_PUSH, rand_literal(), 1'b0));
      end
      send_token(make_token(rse_pkg::CMD_ADD, $urandom, 1'b1));
   endtask

   // well-formed expression with random operands and operators
   task automatic send_expression();
      int          operand_count;
      int          pushed;
      int          level;
      logic [2:0]  cmd;
      logic [31:0] lit;
      logic        fin;
      operand_count = $urandom_range(1, 8);
      pushed = 0;
      level  = 0;
      do begin
         if (pushed < operand_count && (level < 2 || $urandom_range(1) == 0)) begin
            cmd = rse_pkg::CMD_PUSH;
            lit = rand_literal();
            pushed++;
            level++;
         end else begin
            cmd = 3'(rse_pkg::CMD_ADD + $urandom_range(3));
            lit = $urandom;
            level--;
         end
         fin = (pushed == operand_count) && (level == 1);
         send_token(make_token(cmd, lit, fin));
      end while (!fin);
   endtask

   initial begin
      int phase_end;
      int pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // underflow on empty and one-entry stacks, wrap on add
      send_token(make_token(rse_pkg::CMD_ADD, 32'h0, 1'b0));
      send_token(make_token(rse_pkg::CMD_PUSH, 32'h7fff_ffff, 1'b0));
      send_token(make_token(rse_pkg::CMD_SUB, 32'hffff_ffff, 1'b0));
      send_token(make_token(rse_pkg::CMD_PUSH, 32'h1, 1'b0));
      send_token(make_token(rse_pkg::CMD_ADD, 32'h0, 1'b0));
      // most negative over minus one, then divide by zero
      send_token(make_token(rse_pkg::CMD_PUSH, 32'hffff_ffff, 1'b0));
      send_token(make_token(rse_pkg::CMD_DIV, 32'h0, 1'b0));
      send_token(make_token(rse_pkg::CMD_PUSH, 32'h0, 1'b0));
      send_token(make_token(rse_pkg::CMD_DIV, 32'h0, 1'b0));
      send_token(make_token(rse_pkg::CMD_MUL, 32'h0, 1'b0));
      send_token(make_token(CMD_RSVD5, 32'h1234_5678, 1'b0));
      send_token(make_token(CMD_RSVD6, 32'hffff_ffff, 1'b0));
      send_token(make_token(CMD_RSVD7, 32'h8000_0000, 1'b1));
      // truncating divide of a negative, wrapping multiply and subtract
      send_token(make_token(rse_pkg::CMD_PUSH, 32'hffff_fff9, 1'b0));
      send_token(make_token(rse_pkg::CMD_PUSH, 32'h2, 1'b0));
      send_token(make_token(rse_pkg::CMD_DIV, 32'h0, 1'b0));
      send_token(make_token(rse_pkg::CMD_PUSH, 32'h8000_0000, 1'b0));
      send_token(make_token(rse_pkg::CMD_MUL, 32'h0, 1'b0));
      send_token(make_token(rse_pkg::CMD_PUSH, 32'h7fff_ffff, 1'b0));
      send_token(make_token(rse_pkg::CMD_SUB, 32'h0, 1'b0));
      // error on the closing token still clears the stack
      send_token(make_token(rse_pkg::CMD_PUSH, 32'h0, 1'b0));
      send_token(make_token(rse_pkg::CMD_DIV, 32'h0, 1'b1));
      send_token(make_token(rse_pkg::CMD_SUB, 32'h0, 1'b1));
      // fill to the top, one push past it overflows
      send_fill(rse_pkg::STACK_DEPTH + 1);
      hold_sender();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin push_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin push_idle_pct = 86; pop_stall_pct = 0;  end
            2: begin push_idle_pct = 0;  pop_stall_pct = 86; end
            default: begin push_idle_pct = 30; pop_stall_pct = 30; end
         endcase
         phase_end = tokens_sent + ITEMS_PER_PHASE;
         while (tokens_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 82) begin
               send_expression();
            end else if (pick < 97) begin
               send_token(make_token(3'($urandom_range(7)), $urandom,
                                     $urandom_range(3) == 0));
            end else begin
               send_fill($urandom_range(rse_pkg::STACK_DEPTH - 4, rse_pkg::STACK_DEPTH + 2));
            end
         end
         hold_sender();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS rpn_stack_evaluator");
      end else begin
         $display("FAIL rpn_stack_evaluator");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/rse_pkg.sv
rtl/rse_fifo.sv
rtl/rse_front.sv
rtl/rse_iter.sv
rtl/rse_exec.sv
rtl/rpn_stack_evaluator.sv
tb/rse_checker.sv
tb/tb_rpn_stack_evaluator.sv
